// File: hw/rtl/dsds_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package dsds_pkg;

  localparam int DEPTH_W        = 25;
  localparam int MAX_WIDTH_DEF  = 256;
  localparam int MAX_HEIGHT_DEF = 128;

  localparam logic [DEPTH_W-1:0] DEPTH_ONE = 25'h100_0000;

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  localparam logic [1:0] RES_CENTER  = 2'd0;
  localparam logic [1:0] RES_BEST    = 2'd1;
  localparam logic [1:0] RES_OUTSIDE = 2'd2;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [7:0]         pos_x;
    logic [6:0]         pos_y;
    logic [DEPTH_W-1:0] depth_value;
  } in_item_t;

  typedef struct packed {
    logic [DEPTH_W-1:0] dilated_depth;
    logic               read_outside;
  } out_item_t;

  typedef struct packed {
    logic       load;
    logic       sweep_clr;
    logic       sweep;
    logic       wr;
    logic       rd_center;
    logic       nb_clr;
    logic       nb_step;
    logic       out_load;
    logic [1:0] res_sel;
  } dp_cmd_t;

  typedef struct packed {
    logic in_area;
    logic covered;
    logic sweep_last;
    logic nb_last;
    logic out_free;
  } dp_status_t;

endpackage
`default_nettype wire

// File: hw/rtl/dsds_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module dsds_ram #(
  parameter int WIDTH = 25,
  parameter int DEPTH = 32768,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic             re,
  input  wire logic [AW-1:0]    addr,
  input  wire logic [WIDTH-1:0] wdata,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read data holds until the next read is issued.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end else if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/dsds_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module dsds_ctrl
  import dsds_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  input  wire logic [1:0] in_opcode,
  output logic            in_stall,
  input  wire dp_status_t status,
  output dp_cmd_t         cmd
);

  localparam logic [2:0] S_SWEEP  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_WRITE  = 3'd2;
  localparam logic [2:0] S_CENTER = 3'd3;
  localparam logic [2:0] S_CHECK  = 3'd4;
  localparam logic [2:0] S_SCAN   = 3'd5;
  localparam logic [2:0] S_DRAIN  = 3'd6;
  localparam logic [2:0] S_RESULT = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;
  logic [1:0] res_sel;
  logic [1:0] res_sel_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next    = state;
    res_sel_next  = res_sel;
    cmd           = '0;
    cmd.res_sel   = res_sel;
    case (state)
      S_SWEEP: begin
        cmd.sweep = 1'b1;
        if (status.sweep_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          case (in_opcode)
            OP_CLEAR: begin
              cmd.sweep_clr = 1'b1;
              state_next    = S_SWEEP;
            end
            OP_WRITE: state_next = S_WRITE;
            OP_READ:  state_next = S_CENTER;
            default:  state_next = S_IDLE;
          endcase
        end
      end
      S_WRITE: begin
        cmd.wr     = status.in_area;
        state_next = S_IDLE;
      end
      S_CENTER: begin
        if (status.in_area) begin
          cmd.rd_center = 1'b1;
          state_next    = S_CHECK;
        end else begin
          res_sel_next = RES_OUTSIDE;
          state_next   = S_RESULT;
        end
      end
      S_CHECK: begin
        if (status.covered) begin
          res_sel_next = RES_CENTER;
          state_next   = S_RESULT;
        end else begin
          cmd.nb_clr = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.nb_step = 1'b1;
        if (status.nb_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        // The last neighbor's data is folded into the maximum at this edge.
        res_sel_next = RES_BEST;
        state_next   = S_RESULT;
      end
      S_RESULT: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_SWEEP;
      res_sel <= RES_CENTER;
    end else begin
      state   <= state_next;
      res_sel <= res_sel_next;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/dsds_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module dsds_datapath
  import dsds_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire in_item_t   in_data,
  input  wire logic       cfg_valid,
  input  wire logic       cfg_index,
  input  wire logic [8:0] cfg_data,
  input  wire dp_cmd_t    cmd,
  output dp_status_t      status,
  output logic            out_valid,
  input  wire logic       out_stall,
  output out_item_t       out_data
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [8:0]         active_width;
  logic [7:0]         active_height;
  in_item_t           item;
  logic [AW-1:0]      sweep_cnt;
  logic [1:0]         dxi;
  logic [1:0]         dyi;
  logic               pend;
  logic [DEPTH_W-1:0] best;

  logic [8:0]         eff_w;
  logic [7:0]         eff_h;
  logic [8:0]         x_inc;
  logic [7:0]         y_inc;
  logic               nb_in;
  logic [7:0]         nx;
  logic [6:0]         ny;
  logic [7:0]         col;
  logic [6:0]         row;
  logic [AW-1:0]      addr;
  logic               we;
  logic               re;
  logic [DEPTH_W-1:0] wdata;
  logic [DEPTH_W-1:0] rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_width  <= 9'd256;
      active_height <= 8'd128;
    end else if (cfg_valid) begin
      if (cfg_index == REG_WIDTH) begin
        active_width <= cfg_data;
      end else begin
        active_height <= cfg_data[7:0];
      end
    end
  end

  assign eff_w = (32'(active_width) > MAX_WIDTH) ? 9'(MAX_WIDTH) : active_width;
  assign eff_h = (32'(active_height) > MAX_HEIGHT) ? 8'(MAX_HEIGHT) : active_height;

  assign x_inc = {1'b0, item.pos_x} + 9'd1;
  assign y_inc = {1'b0, item.pos_y} + 8'd1;

  assign status.in_area = ({1'b0, item.pos_x} < eff_w) && ({1'b0, item.pos_y} < eff_h);

  // Window position offsets are index minus one in each direction.
  always_comb begin
    nb_in = 1'b1;
    if (dxi == 2'd0 && item.pos_x == 8'd0) begin
      nb_in = 1'b0;
    end
    if (dxi == 2'd2 && !(x_inc < eff_w)) begin
      nb_in = 1'b0;
    end
    if (dyi == 2'd0 && item.pos_y == 7'd0) begin
      nb_in = 1'b0;
    end
    if (dyi == 2'd2 && !(y_inc < eff_h)) begin
      nb_in = 1'b0;
    end
  end

  assign nx = item.pos_x + 8'(dxi) - 8'd1;
  assign ny = item.pos_y + 7'(dyi) - 7'd1;

  assign col  = cmd.nb_step ? nx : item.pos_x;
  assign row  = cmd.nb_step ? ny : item.pos_y;
  assign addr = cmd.sweep ? sweep_cnt
                          : AW'(AW'(row) * AW'(MAX_WIDTH)) + AW'(col);

  assign we = cmd.sweep || cmd.wr;
  assign re = cmd.rd_center || (cmd.nb_step && nb_in);

  always_comb begin
    if (cmd.sweep || item.depth_value >= DEPTH_ONE) begin
      wdata = DEPTH_ONE;
    end else begin
      wdata = item.depth_value;
    end
  end

  dsds_ram #(
    .WIDTH (DEPTH_W),
    .DEPTH (DEPTH)
  ) u_frame (
    .clk   (clk),
    .we    (we),
    .re    (re),
    .addr  (addr),
    .wdata (wdata),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.sweep_clr) begin
      sweep_cnt <= '0;
    end else if (cmd.sweep) begin
      sweep_cnt <= (sweep_cnt == AW'(DEPTH - 1)) ? '0 : sweep_cnt + AW'(1);
    end
  end

  assign status.sweep_last = (sweep_cnt == AW'(DEPTH - 1));
  assign status.covered    = (rdata < DEPTH_ONE);
  assign status.nb_last    = (dxi == 2'd2) && (dyi == 2'd2);

  always_ff @(posedge clk) begin
    if (rst) begin
      dxi  <= 2'd0;
      dyi  <= 2'd0;
      pend <= 1'b0;
    end else begin
      pend <= cmd.nb_step && nb_in;
      if (cmd.nb_clr) begin
        dxi <= 2'd0;
        dyi <= 2'd0;
      end else if (cmd.nb_step) begin
        if (dxi == 2'd2) begin
          dxi <= 2'd0;
          dyi <= dyi + 2'd1;
        end else begin
          dxi <= dxi + 2'd1;
        end
      end
    end
  end

  // Running maximum over covered neighbors; read data lands in the cycle after issue.
  always_ff @(posedge clk) begin
    if (cmd.nb_clr) begin
      best <= '0;
    end else if (pend && rdata < DEPTH_ONE && rdata > best) begin
      best <= rdata;
    end
  end

  assign status.out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      case (cmd.res_sel)
        RES_CENTER: begin
          out_data.dilated_depth <= rdata;
          out_data.read_outside  <= 1'b0;
        end
        RES_BEST: begin
          out_data.dilated_depth <= (best == '0) ? DEPTH_ONE : best;
          out_data.read_outside  <= 1'b0;
        end
        default: begin
          out_data.dilated_depth <= DEPTH_ONE;
          out_data.read_outside  <= 1'b1;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/depth_scatter_dilate_store_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Write: an item passes through S_WRITE before the next is taken. Read: the result
// is registered via S_CENTER outside the active area, via S_CHECK when the center is
// covered, and via S_CHECK, S_SCAN and S_DRAIN when the 3x3 window is scanned; up to
// nine window reads share the frame memory's single port, one a cycle. Clear sweeps
// the store via S_SWEEP. After reset the block sweeps the whole store to empty and
// stalls input meanwhile; configuration writes are taken at any time.
module depth_scatter_dilate_store_core
  import dsds_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire in_item_t   in_data,
  output logic            out_valid,
  input  wire logic       out_stall,
  output out_item_t       out_data,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic       cfg_index,
  input  wire logic [8:0] cfg_data
);

  dp_cmd_t    cmd;
  dp_status_t status;

  assign cfg_ready = 1'b1;

  dsds_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_opcode (in_data.opcode),
    .in_stall  (in_stall),
    .status    (status),
    .cmd       (cmd)
  );

  dsds_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire
